FILE: rtl/ocra_pkg.sv
// ----------------------------------------------------------------------------
// Odd-cover rectangle area package
// Shared widths, state codes and types of the odd-cover area core.
// ----------------------------------------------------------------------------
package ocra_pkg;

   localparam int COORD_W = 31;
   localparam int AREA_W  = 63;
   localparam int LEN_W   = 32;
   localparam int EV_W    = 3 * COORD_W;

   typedef logic [4:0] state_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [EV_W-1:0] event_type;

   localparam state_type ST_IDLE = 5'd0;
   localparam state_type ST_WR0  = 5'd1;
   localparam state_type ST_WR1  = 5'd2;
   localparam state_type ST_SI   = 5'd3;
   localparam state_type ST_SV   = 5'd4;
   localparam state_type ST_SR   = 5'd5;
   localparam state_type ST_SC   = 5'd6;
   localparam state_type ST_CLR  = 5'd7;
   localparam state_type ST_ER   = 5'd8;
   localparam state_type ST_EV   = 5'd9;
   localparam state_type ST_MUL  = 5'd10;
   localparam state_type ST_ACC  = 5'd11;
   localparam state_type ST_BS   = 5'd12;
   localparam state_type ST_BC   = 5'd13;
   localparam state_type ST_F0   = 5'd14;
   localparam state_type ST_F1   = 5'd15;
   localparam state_type ST_F2   = 5'd16;
   localparam state_type ST_NXT  = 5'd17;
   localparam state_type ST_OUT  = 5'd18;

endpackage

FILE: rtl/ocra_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ocra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

FILE: rtl/odd_cover_rectangle_area_core.sv
// ----------------------------------------------------------------------------
// Odd-cover rectangle area core
// Collects rectangles and returns the area covered an odd number of times.
//
//  channel | ports                               | transfer
//  req     | start, busy, req_*                  | start high while busy low
//  rsp     | rsp_valid, rsp_odd_area             | one cycle with rsp_valid high
//
// A rectangle is stored in WR0 and WR1. A final rectangle then starts the
// computation: two insertion sorts of m = 2*rects entries, clearing m parity
// bits and, per event, two binary searches plus a flip of each y interval
// that it covers. Each memory has a single read port. Reset is synchronous
// and empties the set; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module odd_cover_rectangle_area_core #(
   parameter int MAX_RECTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [30:0] req_left_x,
   input  logic [30:0] req_low_y,
   input  logic [30:0] req_right_x,
   input  logic [30:0] req_high_y,
   input  logic        req_final_rect,
   output logic        rsp_valid,
   output logic [62:0] rsp_odd_area
);

   localparam int DEPTH = 2 * MAX_RECTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_RECTS + 1);
   localparam int MW    = CW + 1;
   localparam int CW_   = ocra_pkg::COORD_W;
   localparam int EW    = ocra_pkg::EV_W;
   localparam int LW    = ocra_pkg::LEN_W;
   localparam int RW    = ocra_pkg::AREA_W;

   ocra_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [MW-1:0] m_ff, m_in, i_ff, i_in, j_ff, j_in;
   logic [MW-1:0] lo_ff, lo_in, hi_ff, hi_in, a_ff, a_in, b_ff, b_in, idx_ff, idx_in;
   ocra_pkg::event_type v_ff, v_in;
   logic sel_ff, sel_in, bsel_ff, bsel_in, par_ff, par_in;
   ocra_pkg::coord_type ylo_ff, ylo_in, evlo_ff, evlo_in, evhi_ff, evhi_in;
   ocra_pkg::coord_type prev_ff, prev_in;
   ocra_pkg::coord_type lx_ff, lx_in, ly_ff, ly_in, rx_ff, rx_in, hy_ff, hy_in;
   logic fin_ff, fin_in, ok_ff, ok_in;
   logic [LW-1:0] dx_ff, dx_in, cov_ff, cov_in;
   logic [2*LW-1:0] prod_ff, prod_in;
   logic [RW-1:0] total_ff, total_in;

   logic y_we, e_we, p_we, p_wd, p_rd;
   logic [AW-1:0] y_wa, y_ra, e_wa, e_ra, p_wa, p_ra, k_addr;
   ocra_pkg::coord_type y_wd, y_rd, skey_v, skey_d, bkey;
   ocra_pkg::event_type e_wd, e_rd, d_word;
   logic [MW:0] mid_sum;
   logic [MW-1:0] mid, i_next;
   logic [LW-1:0] span;

   ocra_ram #(.WIDTH(CW_), .DEPTH(DEPTH)) u_yram (
      .clock(clock), .wr_en(y_we), .wr_addr(y_wa), .wr_data(y_wd),
      .rd_addr(y_ra), .rd_data(y_rd));
   ocra_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_eram (
      .clock(clock), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(e_ra), .rd_data(e_rd));
   ocra_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_pram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));

   assign busy         = (state_ff != ocra_pkg::ST_IDLE);
   assign rsp_valid    = (state_ff == ocra_pkg::ST_OUT);
   assign rsp_odd_area = total_ff;

   assign k_addr  = AW'({count_ff, 1'b0});
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[MW:1];
   assign i_next  = i_ff + MW'(1);
   assign d_word  = sel_ff ? e_rd : {{(EW-CW_){1'b0}}, y_rd};
   assign skey_v  = sel_ff ? v_ff[EW-1 -: CW_] : v_ff[CW_-1:0];
   assign skey_d  = d_word[sel_ff ? EW-1 : CW_-1 -: CW_];
   assign bkey    = bsel_ff ? evhi_ff : evlo_ff;
   assign span    = LW'(y_rd) - LW'(ylo_ff);

   always_comb begin
      state_in = state_ff;  count_in = count_ff; m_in = m_ff; i_in = i_ff; j_in = j_ff;
      lo_in = lo_ff; hi_in = hi_ff; a_in = a_ff; b_in = b_ff; idx_in = idx_ff;
      v_in = v_ff; sel_in = sel_ff; bsel_in = bsel_ff; par_in = par_ff;
      ylo_in = ylo_ff; evlo_in = evlo_ff; evhi_in = evhi_ff; prev_in = prev_ff;
      lx_in = lx_ff; ly_in = ly_ff; rx_in = rx_ff; hy_in = hy_ff;
      fin_in = fin_ff; ok_in = ok_ff;
      dx_in = dx_ff; cov_in = cov_ff; prod_in = prod_ff; total_in = total_ff;
      y_we = 1'b0; y_wa = '0; y_wd = '0; y_ra = '0;
      e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
      p_we = 1'b0; p_wa = '0; p_wd = 1'b0; p_ra = '0;
      unique case (state_ff)
         ocra_pkg::ST_IDLE: begin
            if (start) begin
               lx_in = req_left_x; ly_in = req_low_y;
               rx_in = req_right_x; hy_in = req_high_y;
               fin_in = req_final_rect;
               ok_in = (count_ff < CW'(MAX_RECTS));
               state_in = ocra_pkg::ST_WR0;
            end
         end
         ocra_pkg::ST_WR0: begin
            y_we = ok_ff; y_wa = k_addr; y_wd = ly_ff;
            e_we = ok_ff; e_wa = k_addr; e_wd = {lx_ff, ly_ff, hy_ff};
            state_in = ocra_pkg::ST_WR1;
         end
         ocra_pkg::ST_WR1: begin
            y_we = ok_ff; y_wa = k_addr | AW'(1); y_wd = hy_ff;
            e_we = ok_ff; e_wa = k_addr | AW'(1); e_wd = {rx_ff, ly_ff, hy_ff};
            count_in = ok_ff ? count_ff + CW'(1) : count_ff;
            if (fin_ff) begin
               m_in = {count_in, 1'b0};
               sel_in = 1'b0;
               i_in = MW'(1);
               state_in = ocra_pkg::ST_SI;
            end else begin
               state_in = ocra_pkg::ST_IDLE;
            end
         end
         ocra_pkg::ST_SI: begin
            y_ra = i_ff[AW-1:0];
            e_ra = i_ff[AW-1:0];
            if (i_ff < m_ff) begin
               state_in = ocra_pkg::ST_SV;
            end else if (!sel_ff) begin
               sel_in = 1'b1;
               i_in = MW'(1);
            end else begin
               i_in = '0;
               state_in = ocra_pkg::ST_CLR;
            end
         end
         ocra_pkg::ST_SV: begin
            v_in = d_word;
            j_in = i_ff;
            state_in = ocra_pkg::ST_SR;
         end
         ocra_pkg::ST_SR: begin
            y_ra = AW'(j_ff - MW'(1));
            e_ra = AW'(j_ff - MW'(1));
            if (j_ff == '0) begin
               y_we = !sel_ff; y_wa = j_ff[AW-1:0]; y_wd = v_ff[CW_-1:0];
               e_we = sel_ff;  e_wa = j_ff[AW-1:0]; e_wd = v_ff;
               i_in = i_next;
               state_in = ocra_pkg::ST_SI;
            end else begin
               state_in = ocra_pkg::ST_SC;
            end
         end
         ocra_pkg::ST_SC: begin
            y_wa = j_ff[AW-1:0];
            e_wa = j_ff[AW-1:0];
            y_we = !sel_ff;
            e_we = sel_ff;
            if (skey_d > skey_v) begin
               y_wd = d_word[CW_-1:0]; e_wd = d_word;
               j_in = j_ff - MW'(1);
               state_in = ocra_pkg::ST_SR;
            end else begin
               y_wd = v_ff[CW_-1:0]; e_wd = v_ff;
               i_in = i_next;
               state_in = ocra_pkg::ST_SI;
            end
         end
         ocra_pkg::ST_CLR: begin
            if (i_ff < m_ff) begin
               p_we = 1'b1; p_wa = i_ff[AW-1:0]; p_wd = 1'b0;
               i_in = i_next;
            end else begin
               i_in = '0; cov_in = '0; total_in = '0;
               state_in = (m_ff == '0) ? ocra_pkg::ST_OUT : ocra_pkg::ST_ER;
            end
         end
         ocra_pkg::ST_ER: begin
            e_ra = i_ff[AW-1:0];
            state_in = ocra_pkg::ST_EV;
         end
         ocra_pkg::ST_EV: begin
            dx_in = (i_ff == '0) ? '0 :
                    LW'(ocra_pkg::coord_type'(e_rd[EW-1 -: CW_])) - LW'(prev_ff);
            prev_in = e_rd[EW-1 -: CW_];
            evlo_in = e_rd[2*CW_-1 -: CW_];
            evhi_in = e_rd[CW_-1:0];
            state_in = ocra_pkg::ST_MUL;
         end
         ocra_pkg::ST_MUL: begin
            prod_in = (2*LW)'(dx_ff) * (2*LW)'(cov_ff);
            bsel_in = 1'b0; lo_in = '0; hi_in = m_ff;
            state_in = ocra_pkg::ST_ACC;
         end
         ocra_pkg::ST_ACC: begin
            total_in = total_ff + prod_ff[RW-1:0];
            state_in = ocra_pkg::ST_BS;
         end
         ocra_pkg::ST_BS: begin
            y_ra = mid[AW-1:0];
            if (lo_ff < hi_ff) begin
               state_in = ocra_pkg::ST_BC;
            end else if (!bsel_ff) begin
               a_in = lo_ff; bsel_in = 1'b1; lo_in = '0; hi_in = m_ff;
            end else begin
               b_in = lo_ff; idx_in = a_ff;
               state_in = ocra_pkg::ST_F0;
            end
         end
         ocra_pkg::ST_BC: begin
            if (y_rd < bkey) begin
               lo_in = mid + MW'(1);
            end else begin
               hi_in = mid;
            end
            state_in = ocra_pkg::ST_BS;
         end
         ocra_pkg::ST_F0: begin
            y_ra = idx_ff[AW-1:0];
            p_ra = idx_ff[AW-1:0];
            state_in = (idx_ff < b_ff) ? ocra_pkg::ST_F1 : ocra_pkg::ST_NXT;
         end
         ocra_pkg::ST_F1: begin
            ylo_in = y_rd; par_in = p_rd;
            y_ra = AW'(idx_ff + MW'(1));
            state_in = ocra_pkg::ST_F2;
         end
         ocra_pkg::ST_F2: begin
            cov_in = par_ff ? cov_ff - span : cov_ff + span;
            p_we = 1'b1; p_wa = idx_ff[AW-1:0]; p_wd = !par_ff;
            idx_in = idx_ff + MW'(1);
            state_in = ocra_pkg::ST_F0;
         end
         ocra_pkg::ST_NXT: begin
            i_in = i_next;
            state_in = (i_next < m_ff) ? ocra_pkg::ST_ER : ocra_pkg::ST_OUT;
         end
         ocra_pkg::ST_OUT: begin
            count_in = '0;
            state_in = ocra_pkg::ST_IDLE;
         end
         default: begin
            state_in = ocra_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ocra_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      m_ff <= m_in; i_ff <= i_in; j_ff <= j_in;
      lo_ff <= lo_in; hi_ff <= hi_in; a_ff <= a_in; b_ff <= b_in; idx_ff <= idx_in;
      v_ff <= v_in; sel_ff <= sel_in; bsel_ff <= bsel_in; par_ff <= par_in;
      ylo_ff <= ylo_in; evlo_ff <= evlo_in; evhi_ff <= evhi_in; prev_ff <= prev_in;
      lx_ff <= lx_in; ly_ff <= ly_in; rx_ff <= rx_in; hy_ff <= hy_in;
      fin_ff <= fin_in; ok_ff <= ok_in;
      dx_ff <= dx_in; cov_ff <= cov_in; prod_ff <= prod_in; total_ff <= total_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RECTS))
      else $error("rectangle count exceeds the store size");
   a_flip_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ocra_pkg::ST_F1) |-> (idx_ff < m_ff))
      else $error("flip index beyond the coordinate list");
   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (count_ff == '0))
      else $error("set not emptied after a result");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");
`endif

endmodule

FILE: tb/odd_cover_rectangle_area_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Odd-cover rectangle area core testbench
// Sends sets of rectangles through the command port. Each set's odd-covered
// area is taken from the directed table or predicted by an independent sweep
// over compressed y intervals and compared with the core's single response.
// ----------------------------------------------------------------------------
module odd_cover_rectangle_area_core_test;

   localparam int HELD_MAX = 1024;
   localparam int WATCHDOG_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 450;

   typedef struct {
      ocra_pkg::coord_type left_x;
      ocra_pkg::coord_type low_y;
      ocra_pkg::coord_type right_x;
      ocra_pkg::coord_type high_y;
      bit final_rect;
      bit typed;
      logic [ocra_pkg::AREA_W-1:0] area;
   } rect_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [30:0] req_left_x = '0;
   logic [30:0] req_low_y = '0;
   logic [30:0] req_right_x = '0;
   logic [30:0] req_high_y = '0;
   logic req_final_rect = 1'b0;
   logic rsp_valid;
   logic [62:0] rsp_odd_area;

   logic [ocra_pkg::AREA_W-1:0] pending_areas[$];
   int errors = 0;
   int rects_sent = 0;
   int sets_checked = 0;
   int idle_cycles = 0;
   bit gaps_on = 1'b1;

   longint held_lx[HELD_MAX];
   longint held_ly[HELD_MAX];
   longint held_rx[HELD_MAX];
   longint held_hy[HELD_MAX];
   int held_count = 0;

   longint ys[2*HELD_MAX];
   longint ex[2*HELD_MAX];
   longint elo[2*HELD_MAX];
   longint ehi[2*HELD_MAX];
   bit parity[2*HELD_MAX];

   rect_row_type directed[14];

   odd_cover_rectangle_area_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_left_x(req_left_x), .req_low_y(req_low_y), .req_right_x(req_right_x),
      .req_high_y(req_high_y), .req_final_rect(req_final_rect),
      .rsp_valid(rsp_valid), .rsp_odd_area(rsp_odd_area)
   );

   always #1 clock = ~clock;

   function automatic logic [ocra_pkg::AREA_W-1:0] odd_cover_area();
      int n, nu, i, j, k;
      longint v, t0, t1, cur, prev, h;
      bit [63:0] total;
      n = held_count * 2;
      for (i = 0; i < held_count; i++) begin
         ys[2*i] = held_ly[i];
         ys[2*i+1] = held_hy[i];
         ex[2*i] = held_lx[i];
         ex[2*i+1] = held_rx[i];
         elo[2*i] = held_ly[i];
         elo[2*i+1] = held_ly[i];
         ehi[2*i] = held_hy[i];
         ehi[2*i+1] = held_hy[i];
      end
      for (i = 1; i < n; i++) begin
         v = ys[i];
         j = i;
         while (j > 0 && ys[j-1] > v) begin
            ys[j] = ys[j-1];
            j--;
         end
         ys[j] = v;
      end
      nu = 0;
      for (i = 0; i < n; i++) begin
         if (nu == 0 || ys[nu-1] != ys[i]) begin
            ys[nu] = ys[i];
            nu++;
         end
      end
      for (i = 1; i < n; i++) begin
         v = ex[i];
         t0 = elo[i];
         t1 = ehi[i];
         j = i;
         while (j > 0 && ex[j-1] > v) begin
            ex[j] = ex[j-1];
            elo[j] = elo[j-1];
            ehi[j] = ehi[j-1];
            j--;
         end
         ex[j] = v;
         elo[j] = t0;
         ehi[j] = t1;
      end
      for (k = 0; k < nu; k++) parity[k] = 1'b0;
      total = '0;
      prev = ex[0];
      i = 0;
      while (i < n) begin
         cur = ex[i];
         h = 0;
         for (k = 0; k + 1 < nu; k++) begin
            if (parity[k]) h += ys[k+1] - ys[k];
         end
         total += 64'(cur - prev) * 64'(h);
         prev = cur;
         while (i < n && ex[i] == cur) begin
            if (elo[i] < ehi[i]) begin
               for (k = 0; k + 1 < nu; k++) begin
                  if (ys[k] >= elo[i] && ys[k+1] <= ehi[i]) parity[k] = ~parity[k];
               end
            end
            i++;
         end
      end
      held_count = 0;
      return total[ocra_pkg::AREA_W-1:0];
   endfunction

   task automatic send_rect(input ocra_pkg::coord_type lx, input ocra_pkg::coord_type ly,
                            input ocra_pkg::coord_type rx, input ocra_pkg::coord_type hy,
                            input bit fin, input bit typed,
                            input logic [ocra_pkg::AREA_W-1:0] typed_area);
      logic [ocra_pkg::AREA_W-1:0] predicted;
      bit taken;
      while (gaps_on && $urandom_range(99) < 24) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_left_x <= lx;
      req_low_y <= ly;
      req_right_x <= rx;
      req_high_y <= hy;
      req_final_rect <= fin;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      if (held_count < HELD_MAX) begin
         held_lx[held_count] = lx;
         held_ly[held_count] = ly;
         held_rx[held_count] = rx;
         held_hy[held_count] = hy;
         held_count++;
      end
      rects_sent++;
      if (fin) begin
         predicted = odd_cover_area();
         pending_areas.push_back(typed ? typed_area : predicted);
      end
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_areas.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   function automatic ocra_pkg::coord_type pick_coord(input bit wide);
      if (wide) return ocra_pkg::coord_type'($urandom());
      return ocra_pkg::coord_type'(int'($urandom_range(40)) - 20);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_areas.size() == 0) begin
            $error("odd_area: unexpected result %0d", rsp_odd_area);
            errors++;
         end else begin
            if (rsp_odd_area !== pending_areas[0]) begin
               $error("odd_area: expected %0d, actual %0d", pending_areas[0], rsp_odd_area);
               errors++;
            end
            void'(pending_areas.pop_front());
            sets_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int s, r, set_len, sent;
      bit wide, fin;
      ocra_pkg::coord_type a, b, c, d;
      directed[0] = '{0, 0, 2, 3, 1, 1, 6};
      directed[1] = '{5, 0, 1, 2, 1, 1, 8};
      directed[2] = '{0, 5, 4, 1, 1, 1, 0};
      directed[3] = '{0, 3, 4, 3, 1, 1, 0};
      directed[4] = '{0, 0, 10, 10, 0, 0, 0};
      directed[5] = '{0, 0, 10, 10, 1, 1, 0};
      directed[6] = '{0, 0, 4, 4, 0, 0, 0};
      directed[7] = '{1, 1, 3, 3, 1, 1, 12};
      directed[8] = '{-31'sd1073741824, -31'sd1073741824, 31'sd1073741823,
                      31'sd1073741823, 1, 1, 63'd4611686014132420609};
      directed[9] = '{31'sd1073741823, -31'sd1073741824, -31'sd1073741824,
                      31'sd1073741823, 1, 1, 63'd4611686014132420609};
      directed[10] = '{7, 0, 7, 9, 1, 1, 0};
      directed[11] = '{0, 0, 6, 6, 0, 0, 0};
      directed[12] = '{3, 3, 9, 9, 1, 1, 54};
      directed[13] = '{-1, -1, 0, 0, 1, 1, 1};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) begin
         send_rect(directed[i].left_x, directed[i].low_y, directed[i].right_x,
                   directed[i].high_y, directed[i].final_rect, directed[i].typed,
                   directed[i].area);
      end
      drain_results();

      for (r = 0; r < HELD_MAX + 6; r++) begin
         send_rect(ocra_pkg::coord_type'(2*r), ocra_pkg::coord_type'(2*r),
                   ocra_pkg::coord_type'(2*r+1), ocra_pkg::coord_type'(2*r+1),
                   r == HELD_MAX + 5, 0, '0);
      end
      drain_results();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         set_len = ($urandom_range(9) == 0) ? $urandom_range(24, 1) : $urandom_range(8, 1);
         wide = $urandom_range(3) == 0;
         for (s = 0; s < set_len; s++) begin
            gaps_on = !(sent > 150 && sent < 300);
            a = pick_coord(wide);
            b = pick_coord(wide);
            c = pick_coord(wide);
            d = pick_coord(wide);
            if ($urandom_range(99) < 85 && b > d) begin
               send_rect(a, d, c, b, s == set_len - 1, 0, '0);
            end else begin
               fin = (s == set_len - 1) || ($urandom_range(49) == 0);
               send_rect(a, b, c, d, fin, 0, '0);
            end
            sent++;
         end
      end
      drain_results();

      $display("Sent %0d rectangles, checked %0d area results, including a full store,",
               rects_sent, sets_checked);
      $display("swapped and inverted rectangles and full-range coordinates.");
      if (errors == 0 && pending_areas.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
